// File: sv/newton_square_root_defines.svh
// Assertion macros of the square root block, used by its port-level checker.
// No dependencies; a file that asserts includes this header by name.
`ifndef NEWTON_SQUARE_ROOT_DEFINES_SVH
`define NEWTON_SQUARE_ROOT_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define NSR_ASSERT_SAME(lbl, clk, ante, cons, msg) \
    lbl: assert property (@(posedge clk) (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define NSR_ASSERT_NEXT(lbl, clk, ante, cons, msg) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// File: sv/nsr_pkg.sv
// Package of the Newton square root block: widths, reset values, codes and the
// control structs between controller and datapath. No dependencies.
package nsr_pkg;

    localparam int VALUE_W           = 64;
    localparam int ROOT_W            = 48;
    localparam int TOL_W             = 33;
    localparam int LIMIT_W           = 7;
    localparam int APB_ADDR_W        = 4;
    localparam int APB_DATA_W        = 64;
    localparam int FRAC_BITS_DEFAULT = 32;

    localparam logic [TOL_W-1:0]   TOL_RESET   = TOL_W'(429);
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(64);
    localparam logic [LIMIT_W-1:0] MAX_STEPS   = LIMIT_W'(64);

    // Register select: address bit 3 (registers sit 8 bytes apart).
    localparam logic REG_IDX_TOL   = 1'b0;
    localparam logic REG_IDX_LIMIT = 1'b1;

    typedef enum logic [1:0] {
        KIND_NEG,
        KIND_TRIV,
        KIND_CONV,
        KIND_NCONV
    } t_kind;

    typedef struct packed {
        logic  load;
        logic  div_start;
        logic  div_bit;
        logic  div_hi;
        logic  upd;
        logic  chk;
        logic  out_load;
        t_kind kind;
    } t_cmd;

    typedef struct packed {
        logic neg;
        logic triv;
        logic conv;
    } t_status;

endpackage

// File: sv/newton_square_root.sv
// Top level of the fixed-point Newton square root block.
// Depends on nsr_pkg, nsr_regs, nsr_ctrl and nsr_dpath.
//
// Usage. A radicand arrives as a request on the slave stream (s_tdata, signed
// fixed point with FRAC_BITS fraction bits) and its square root leaves as one
// request on the master stream (m_tdata, unsigned, same fraction bits), with
// the invalid and not-converged flags in m_tuser. Tolerance and the step cap
// are written over the APB-style port, by the user only while the block is
// idle; the block itself does not enforce this.
// Timing. Negative inputs, zero and exactly one go from acceptance through the
// START and FIN states to the result register. Any other radicand runs N Newton
// steps, N being at most the step cap (64 at most): each step is a bit-serial
// restoring division of (value << FRAC_BITS) by the guess, one quotient bit a
// cycle over 64 + FRAC_BITS bits, then an update state and a convergence test
// state. One radicand is worked on at a time; s_tready is high only while the
// controller is idle.
// Reset (synchronous, active low) empties the result register, returns the
// controller to idle and restores tolerance 429 and step cap 64.
// Stalls. A finished result waits in the output register while m_tready is
// low; the next radicand is already accepted and computed meanwhile, and its
// result is held back until the waiting one has been taken.
module newton_square_root import nsr_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEFAULT
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // APB-style configuration port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    // Slave stream: radicands
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  logic [VALUE_W-1:0]    i_s_tdata,   // [63:0] value
    // Master stream: roots
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    output logic [ROOT_W-1:0]     o_m_tdata,   // [47:0] root
    output logic [1:0]            o_m_tuser    // [0] invalid, [1] not_converged
);

    logic [TOL_W-1:0]   tol;
    logic [LIMIT_W-1:0] limit;
    t_cmd               cmd;
    t_status            status;
    logic               res_invalid;
    logic               res_not_conv;

    nsr_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_tol   (tol),
        .o_limit (limit)
    );

    nsr_ctrl #(.FRAC_BITS(FRAC_BITS)) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .i_limit    (limit),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    nsr_dpath #(.FRAC_BITS(FRAC_BITS)) u_dpath (
        .i_clk           (i_clk),
        .i_value         (i_s_tdata),
        .i_tol           (tol),
        .i_cmd           (cmd),
        .o_status        (status),
        .o_root          (o_m_tdata),
        .o_invalid       (res_invalid),
        .o_not_converged (res_not_conv)
    );

    assign o_m_tuser = {res_not_conv, res_invalid};

endmodule

// File: sv/nsr_regs.sv
// Configuration registers of the square root block behind an APB-style port.
// Depends on nsr_pkg.
module nsr_regs import nsr_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output logic [TOL_W-1:0]      o_tol,
    output logic [LIMIT_W-1:0]    o_limit
);

    logic [TOL_W-1:0]   r_tol;
    logic [LIMIT_W-1:0] r_limit;
    logic               wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol   <= TOL_RESET;
            r_limit <= LIMIT_RESET;
        end else if (wr_en) begin
            case (paddr[3])
                REG_IDX_TOL:   r_tol   <= pwdata[TOL_W-1:0];
                REG_IDX_LIMIT: r_limit <= pwdata[LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3])
            REG_IDX_TOL:   prdata = APB_DATA_W'(r_tol);
            REG_IDX_LIMIT: prdata = APB_DATA_W'(r_limit);
            default:       prdata = '0;
        endcase
    end

    assign o_tol   = r_tol;
    assign o_limit = r_limit;

endmodule

// File: sv/nsr_ctrl.sv
// Controller of the square root block: request handshakes, Newton step and
// division bit sequencing. Depends on nsr_pkg; drives nsr_dpath by t_cmd.
module nsr_ctrl import nsr_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEFAULT
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_s_tvalid,
    output logic               o_s_tready,
    output logic               o_m_tvalid,
    input  logic               i_m_tready,
    input  logic [LIMIT_W-1:0] i_limit,
    input  t_status            i_status,
    output t_cmd               o_cmd
);

    localparam int DIV_BITS = 64 + FRAC_BITS;
    localparam int BIT_W    = $clog2(DIV_BITS);

    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_DIV,
        S_UPD,
        S_CHK,
        S_FIN
    } t_state;

    t_state             r_state, n_state;
    logic [BIT_W-1:0]   r_bit, n_bit;
    logic [LIMIT_W-1:0] r_step, n_step;
    t_kind              r_kind, n_kind;
    logic               r_oval, n_oval;
    logic [LIMIT_W-1:0] limit_eff;
    logic [LIMIT_W-1:0] step_inc;

    // A limit of zero acts as one step, anything above the cap as the cap.
    always_comb begin
        if (i_limit == '0)
            limit_eff = LIMIT_W'(1);
        else if (i_limit > MAX_STEPS)
            limit_eff = MAX_STEPS;
        else
            limit_eff = i_limit;
    end

    assign step_inc = r_step + LIMIT_W'(1);

    always_comb begin
        n_state = r_state;
        n_bit   = r_bit;
        n_step  = r_step;
        n_kind  = r_kind;
        n_oval  = r_oval & ~i_m_tready;
        o_cmd   = '0;
        o_cmd.kind   = r_kind;
        o_cmd.div_hi = (r_bit < BIT_W'(FRAC_BITS));
        case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_START;
                end
            end
            S_START: begin
                if (i_status.neg) begin
                    n_kind  = KIND_NEG;
                    n_state = S_FIN;
                end else if (i_status.triv) begin
                    n_kind  = KIND_TRIV;
                    n_state = S_FIN;
                end else begin
                    o_cmd.div_start = 1'b1;
                    n_bit   = '0;
                    n_step  = '0;
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.div_bit = 1'b1;
                n_bit         = r_bit + BIT_W'(1);
                if (r_bit == BIT_W'(DIV_BITS - 1))
                    n_state = S_UPD;
            end
            S_UPD: begin
                o_cmd.upd = 1'b1;
                n_state   = S_CHK;
            end
            S_CHK: begin
                o_cmd.chk = 1'b1;
                n_step    = step_inc;
                if (i_status.conv) begin
                    n_kind  = KIND_CONV;
                    n_state = S_FIN;
                end else if (step_inc >= limit_eff) begin
                    n_kind  = KIND_NCONV;
                    n_state = S_FIN;
                end else begin
                    o_cmd.div_start = 1'b1;
                    n_bit   = '0;
                    n_state = S_DIV;
                end
            end
            S_FIN: begin
                if (!r_oval || i_m_tready) begin
                    o_cmd.out_load = 1'b1;
                    n_oval  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_bit   <= '0;
            r_step  <= '0;
            r_kind  <= KIND_NEG;
            r_oval  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_bit   <= n_bit;
            r_step  <= n_step;
            r_kind  <= n_kind;
            r_oval  <= n_oval;
        end
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_oval;

endmodule

// File: sv/nsr_dpath.sv
// Datapath of the square root block: radicand and guess registers, a
// bit-serial restoring divider, the Newton update and the result register.
// Depends on nsr_pkg; commanded by nsr_ctrl.
module nsr_dpath import nsr_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEFAULT
) (
    input  logic               i_clk,
    input  logic [VALUE_W-1:0] i_value,
    input  logic [TOL_W-1:0]   i_tol,
    input  t_cmd               i_cmd,
    output t_status            o_status,
    output logic [ROOT_W-1:0]  o_root,
    output logic               o_invalid,
    output logic               o_not_converged
);

    localparam logic [VALUE_W-1:0] ONE_FX = VALUE_W'(1) << FRAC_BITS;

    logic [VALUE_W-1:0] r_x, r_g, r_next, r_rem, r_q, r_sr;
    logic               r_over;
    logic [ROOT_W-1:0]  r_root;
    logic               r_inv, r_nc;

    logic [VALUE_W-1:0] divisor;
    logic [VALUE_W:0]   part_rem;
    logic [VALUE_W:0]   part_sub;
    logic               q_bit;
    logic [VALUE_W-1:0] quot;
    logic [VALUE_W-1:0] n_next;
    logic [VALUE_W-1:0] diff;
    logic [ROOT_W-1:0]  root_sat;

    // A zero guess divides by one instead.
    assign divisor  = (r_g == '0) ? VALUE_W'(1) : r_g;
    assign part_rem = {r_rem, r_sr[VALUE_W-1]};
    assign part_sub = part_rem - {1'b0, divisor};
    assign q_bit    = (part_rem >= {1'b0, divisor});

    // A quotient bit above the word saturates the quotient.
    assign quot   = r_over ? '1 : r_q;
    assign n_next = {1'b0, divisor[VALUE_W-1:1]} + {1'b0, quot[VALUE_W-1:1]}
                  + VALUE_W'(divisor[0] & quot[0]);

    assign diff     = (r_g > r_next) ? (r_g - r_next) : (r_next - r_g);
    assign root_sat = (|r_next[VALUE_W-1:ROOT_W]) ? '1 : r_next[ROOT_W-1:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_x <= i_value;
            r_g <= i_value;
        end
        if (i_cmd.div_start) begin
            r_rem  <= '0;
            r_q    <= '0;
            r_over <= 1'b0;
            r_sr   <= r_x;
        end else if (i_cmd.div_bit) begin
            r_rem  <= q_bit ? part_sub[VALUE_W-1:0] : part_rem[VALUE_W-1:0];
            r_q    <= {r_q[VALUE_W-2:0], q_bit};
            r_over <= r_over | (q_bit & i_cmd.div_hi);
            r_sr   <= {r_sr[VALUE_W-2:0], 1'b0};
        end
        if (i_cmd.upd)
            r_next <= n_next;
        if (i_cmd.chk)
            r_g <= r_next;
        if (i_cmd.out_load) begin
            case (i_cmd.kind)
                KIND_NEG: begin
                    r_root <= '0;
                    r_inv  <= 1'b1;
                    r_nc   <= 1'b0;
                end
                KIND_TRIV: begin
                    r_root <= r_x[ROOT_W-1:0];
                    r_inv  <= 1'b0;
                    r_nc   <= 1'b0;
                end
                KIND_CONV: begin
                    r_root <= root_sat;
                    r_inv  <= 1'b0;
                    r_nc   <= 1'b0;
                end
                default: begin
                    r_root <= root_sat;
                    r_inv  <= 1'b0;
                    r_nc   <= 1'b1;
                end
            endcase
        end
    end

    assign o_status.neg  = r_x[VALUE_W-1];
    assign o_status.triv = (r_x == '0) || (r_x == ONE_FX);
    assign o_status.conv = (diff <= VALUE_W'(i_tol));

    assign o_root          = r_root;
    assign o_invalid       = r_inv;
    assign o_not_converged = r_nc;

endmodule

// File: sv/nsr_checker.sv
// Port-level checks of the square root block, bound to its top level.
// Depends on nsr_pkg and newton_square_root_defines.svh.
`include "newton_square_root_defines.svh"

module nsr_checker import nsr_pkg::*; (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_s_tvalid,
    input logic               o_s_tready,
    input logic [VALUE_W-1:0] i_s_tdata,
    input logic               o_m_tvalid,
    input logic               i_m_tready,
    input logic [ROOT_W-1:0]  o_m_tdata,
    input logic [1:0]         o_m_tuser
);

    // An invalid result carries a zero root and no not-converged flag.
    `NSR_ASSERT_SAME(a_invalid_zero, i_clk,
        i_rst_n && o_m_tvalid && o_m_tuser[0],
        o_m_tdata == '0 && !o_m_tuser[1], "invalid result with nonzero root")

    // Reset empties the result register.
    `NSR_ASSERT_NEXT(a_reset_empty, i_clk, !i_rst_n, !o_m_tvalid,
        "result valid after reset")

    // After taking a non-negative radicand the block is not ready in the cycle after.
    `NSR_ASSERT_NEXT(a_busy_after_accept, i_clk,
        i_rst_n && i_s_tvalid && o_s_tready && i_s_tdata[VALUE_W-1] == 1'b0,
        !o_s_tready, "ready again straight after accepting")

    // A stalled result holds its value.
    `NSR_ASSERT_NEXT(a_stall_hold, i_clk,
        i_rst_n && o_m_tvalid && !i_m_tready,
        o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser),
        "stalled result changed")

endmodule

bind newton_square_root nsr_checker u_nsr_checker (.*);

// File: sim/nsr_root_checker.sv
// Scoreboard for the Newton square root block: watches the APB port and both streams,
// predicts each root from the radicand and compares it with what the block returns.
// Depends on nsr_pkg only.
module nsr_root_checker import nsr_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEFAULT
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_psel,
    input  logic                  i_penable,
    input  logic                  i_pwrite,
    input  logic [APB_ADDR_W-1:0] i_paddr,
    input  logic [APB_DATA_W-1:0] i_pwdata,
    input  logic                  i_pready,
    input  logic                  i_s_tvalid,
    input  logic                  i_s_tready,
    input  logic [VALUE_W-1:0]    i_s_tdata,   // [63:0] value
    input  logic                  i_m_tvalid,
    input  logic                  i_m_tready,
    input  logic [ROOT_W-1:0]     i_m_tdata,   // [47:0] root
    input  logic [1:0]            i_m_tuser,   // [0] invalid, [1] not_converged
    output int                    o_pending,
    output int                    o_errors
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [ROOT_W-1:0]  root;
        logic               invalid;
        logic               not_converged;
    } t_root_expect;

    t_root_expect       pending_roots[$];
    logic [TOL_W-1:0]   tol_q;
    logic [LIMIT_W-1:0] limit_q;
    int                 mismatch_count = 0;

    assign o_errors = mismatch_count;

    task automatic report_mismatch(string what, logic [63:0] value, logic [63:0] got,
                                   logic [63:0] wanted);
        mismatch_count++;
        $display("%0t ns: %s mismatch for radicand %h: got %h, wanted %h",
                 $time, what, value, got, wanted);
    endtask

    // (x << FRAC_BITS) / d at full width, saturated to 64 bits.
    function automatic logic [63:0] fixed_quotient(logic [63:0] x, logic [63:0] d);
        logic [127:0] num;
        logic [127:0] quo;
        num = {64'd0, x} << FRAC_BITS;
        quo = num / {64'd0, d};
        fixed_quotient = (quo[127:64] != '0) ? '1 : quo[63:0];
    endfunction

    // One Newton step: mean of the guess and value/guess, each halved before adding.
    function automatic logic [63:0] newton_update(logic [63:0] x, logic [63:0] g);
        logic [63:0] gd;
        logic [63:0] q;
        gd = (g == '0) ? 64'd1 : g;
        q = fixed_quotient(x, gd);
        newton_update = (gd >> 1) + (q >> 1) + {63'd0, gd[0] & q[0]};
    endfunction

    function automatic t_root_expect predict_root(logic [63:0] x);
        t_root_expect r;
        logic [63:0]  g;
        logic [63:0]  nxt;
        logic [63:0]  diff;
        int           steps;
        bit           met;
        r = '0;
        r.value = x;
        if (x[63]) begin
            r.invalid = 1'b1;
            return r;
        end
        if (x == '0 || x == (64'd1 << FRAC_BITS)) begin
            r.root = x[ROOT_W-1:0];
            return r;
        end
        steps = int'(limit_q);
        if (steps == 0) steps = 1;
        if (steps > int'(MAX_STEPS)) steps = int'(MAX_STEPS);
        g = x;
        nxt = x;
        met = 1'b0;
        for (int n = 0; n < steps && !met; n++) begin
            nxt = newton_update(x, g);
            diff = (g > nxt) ? (g - nxt) : (nxt - g);
            if (diff <= 64'(tol_q)) met = 1'b1;
            else g = nxt;
        end
        r.root = (nxt > 64'({ROOT_W{1'b1}})) ? '1 : nxt[ROOT_W-1:0];
        r.not_converged = !met;
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_root_expect want;
        if (!i_rst_n) begin
            tol_q = TOL_RESET;
            limit_q = LIMIT_RESET;
            pending_roots.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                if (i_paddr[3] == REG_IDX_TOL) tol_q = i_pwdata[TOL_W-1:0];
                else limit_q = i_pwdata[LIMIT_W-1:0];
            end
            if (i_s_tvalid && i_s_tready) begin
                pending_roots.push_back(predict_root(i_s_tdata));
            end
            if (i_m_tvalid && i_m_tready) begin
                if (pending_roots.size() == 0) begin
                    report_mismatch("unrequested root", '0, 64'(i_m_tdata), '0);
                end else begin
                    want = pending_roots.pop_front();
                    if (i_m_tdata != want.root)
                        report_mismatch("root", want.value, 64'(i_m_tdata), 64'(want.root));
                    if (i_m_tuser[0] != want.invalid)
                        report_mismatch("invalid", want.value, 64'(i_m_tuser[0]),
                                        64'(want.invalid));
                    if (i_m_tuser[1] != want.not_converged)
                        report_mismatch("not_converged", want.value, 64'(i_m_tuser[1]),
                                        64'(want.not_converged));
                end
            end
        end
        o_pending <= pending_roots.size();
    end

endmodule

// File: sim/tb_newton_square_root.sv
// Top of the testbench for the Newton square root block: clock, reset, APB writes,
// radicand stimulus and the verdict. Depends on nsr_pkg, newton_square_root and
// nsr_root_checker.
module tb_newton_square_root;
    import nsr_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    // Registers sit 8 bytes apart because the tolerance is wider than 32 bits.
    localparam logic [APB_ADDR_W-1:0] ADDR_TOL   = 4'h0;
    localparam logic [APB_ADDR_W-1:0] ADDR_LIMIT = 4'h8;

    localparam logic [63:0] FIX_ONE  = 64'd1 << FRAC_BITS_DEFAULT;
    localparam logic [63:0] TOL_MAX  = 64'h1_FFFF_FFFF;
    localparam int          TAIL_CYCLES = 6400;  // a little over the longest computation

    // How the two sides of the stream hold back during a phase.
    typedef enum logic [1:0] {
        IDLE_NONE,
        IDLE_SEND,
        IDLE_RECV,
        IDLE_BOTH
    } t_idle_mode;

    // Radicands at the edges of the range and the special cases: zero, exactly one,
    // negatives (including the most negative), the largest positive value, the
    // smallest positive step and values either side of one.
    localparam logic [63:0] EDGE_RADICANDS [15] = '{
        64'h0, FIX_ONE, 64'hFFFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000,
        64'h7FFF_FFFF_FFFF_FFFF, 64'h1, FIX_ONE - 64'd1, FIX_ONE + 64'd1,
        FIX_ONE << 2, FIX_ONE << 1, FIX_ONE >> 2, 64'd9 << FRAC_BITS_DEFAULT,
        64'h5555_5555_5555_5555, 64'h2AAA_AAAA_AAAA_AAAA, 64'hFF
    };

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [VALUE_W-1:0]    s_tdata = '0;    // [63:0] value
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [ROOT_W-1:0]     m_tdata;         // [47:0] root
    logic [1:0]            m_tuser;         // [0] invalid, [1] not_converged

    int         roots_pending;
    int         mismatches;
    t_idle_mode idle_mode = IDLE_NONE;

    newton_square_root dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tuser  (m_tuser)
    );

    nsr_root_checker root_checker (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_psel     (psel),
        .i_penable  (penable),
        .i_pwrite   (pwrite),
        .i_paddr    (paddr),
        .i_pwdata   (pwdata),
        .i_pready   (pready),
        .i_s_tvalid (s_tvalid),
        .i_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .i_m_tdata  (m_tdata),
        .i_m_tuser  (m_tuser),
        .o_pending  (roots_pending),
        .o_errors   (mismatches)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Watchdog. The slowest legal run is roughly 300 requests, some 20 ms; the limit
    // allows several times that.
    initial begin
        #100_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    function automatic int send_idle_pct();
        case (idle_mode)
            IDLE_SEND: send_idle_pct = 68;
            IDLE_BOTH: send_idle_pct = 16;
            default:   send_idle_pct = 0;
        endcase
    endfunction

    function automatic int recv_stall_pct();
        case (idle_mode)
            IDLE_RECV: recv_stall_pct = 68;
            IDLE_BOTH: recv_stall_pct = 16;
            default:   recv_stall_pct = 0;
        endcase
    endfunction

    // The receiver decides afresh every cycle whether it will take a root.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct());
        end
    end

    // Mostly small radicands, which converge quickly; a share of full-width values
    // makes sure every bit of the request is seen at both levels, half of them negative.
    function automatic logic [63:0] random_radicand();
        logic [63:0] r;
        int          k;
        r = {$urandom, $urandom};
        case ($urandom_range(9))
            0, 1, 2: random_radicand = r >> $urandom_range(63, 20);
            3, 4:    random_radicand = r;
            5:       random_radicand = FIX_ONE + 64'($urandom_range(2000)) - 64'd1000;
            6: begin
                // Perfect squares of whole numbers, whose roots are exact.
                k = $urandom_range(46340, 1);
                random_radicand = (64'(k) * 64'(k)) << FRAC_BITS_DEFAULT;
            end
            7:       random_radicand = {1'b0, r[62:0]};
            8:       random_radicand = -(r >> $urandom_range(63, 30));
            default: random_radicand = 64'($urandom_range(1000, 1));
        endcase
    endfunction

    // Offers one radicand and returns at the edge where it is accepted. It is always
    // entered at a rising edge; when no gap is chosen the valid simply stays high.
    task automatic send_radicand(logic [63:0] value);
        while ($urandom_range(99) < send_idle_pct()) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= value;
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
    endtask

    // Lowers the valid and waits until every predicted root has come back. The
    // pending count is registered in the checker, so the task lets it take in the
    // last request before it reads the count.
    task automatic drain_roots();
        s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (roots_pending != 0) @(posedge i_clk);
    endtask

    // APB write: setup cycle, then access cycle held until pready.
    task automatic write_register(logic [APB_ADDR_W-1:0] addr, logic [APB_DATA_W-1:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // Changes both registers with the block idle. The upper data bits carry noise,
    // which the registers must ignore.
    task automatic set_config(logic [TOL_W-1:0] tol, logic [LIMIT_W-1:0] limit);
        drain_roots();
        write_register(ADDR_TOL, {31'($urandom), tol});
        write_register(ADDR_LIMIT, {{(APB_DATA_W - 32){1'b0}}, 25'($urandom), limit});
    endtask

    // A run of random requests; when hold_at is reached the sender waits for every
    // outstanding root before carrying on.
    task automatic send_random(int count, t_idle_mode mode, int hold_at);
        idle_mode = mode;
        for (int i = 0; i < count; i++) begin
            if (i == hold_at) drain_roots();
            send_radicand(random_radicand());
        end
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Edge cases first, with the registers at their reset values.
        idle_mode = IDLE_NONE;
        foreach (EDGE_RADICANDS[i]) send_radicand(EDGE_RADICANDS[i]);

        // Widest tolerance and a step cap above 64, which must act as 64.
        set_config(TOL_MAX[TOL_W-1:0], 7'd127);
        send_random(20, IDLE_SEND, -1);

        // Zero tolerance and a zero cap, which acts as one step: large radicands stop
        // far from their root and the root saturates.
        set_config('0, 7'd0);
        idle_mode = IDLE_RECV;
        send_radicand(64'h7FFF_FFFF_FFFF_FFFF);
        send_radicand(FIX_ONE << 8);
        send_radicand(64'h1);
        send_radicand(FIX_ONE);
        send_radicand(64'h0);
        send_random(20, IDLE_RECV, -1);

        // Zero tolerance with the full cap: rounding oscillation runs out the cap.
        // Each of these requests is slow, so the run is kept short.
        set_config('0, MAX_STEPS);
        send_random(12, IDLE_BOTH, -1);

        // Tightest non-zero tolerance, with a hold-off half way through.
        set_config(33'd1, MAX_STEPS);
        send_random(50, IDLE_BOTH, 25);

        // Back to the reset settings: a stretch with no idling, then an idle sender.
        set_config(TOL_RESET, LIMIT_RESET);
        send_random(40, IDLE_NONE, -1);
        send_random(40, IDLE_SEND, 20);

        // Tolerance of exactly one with a single step.
        set_config(33'h1_0000_0000, 7'd1);
        send_random(20, IDLE_RECV, -1);

        // A few random settings, cycling through the idling patterns.
        for (int round = 0; round < 4; round++) begin
            set_config({1'($urandom), 32'($urandom)} >> $urandom_range(32),
                       7'($urandom_range(127)));
            send_random(15, t_idle_mode'(round), 7);
        end

        drain_roots();
        idle_mode = IDLE_NONE;
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (mismatches == 0 && roots_pending == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// File: files.f
+incdir+sv
sv/nsr_pkg.sv
sv/nsr_regs.sv
sv/nsr_ctrl.sv
sv/nsr_dpath.sv
sv/newton_square_root.sv
sv/nsr_checker.sv
sim/nsr_root_checker.sv
sim/tb_newton_square_root.sv
